FILE: rtl/rc4kct_pkg.sv
// Package for the RC4 key candidate tester: shared types, constants and the microcode ROM.
// It has no dependencies. The sequencer and the top level import it.
`default_nettype none

package rc4kct_pkg;

   localparam int FIELD_COUNT  = 7;
   localparam int PREFIX_BYTES = 4;
   localparam int TABLE_DEPTH  = 256;

   localparam logic [7:0] FIELD_OFFSET [FIELD_COUNT] = '{
      8'h35, 8'h29, 8'h40, 8'h73, 8'h5d, 8'h3f, 8'h6b
   };

   localparam logic [31:0] KEY_PREFIX_RESET    = 32'h6230_3021;
   localparam logic [31:0] MATCH_PATTERN_RESET = 32'h4B65_793A;  // "Key:"

   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_CIPHER_0_7   = 3'd0;
   localparam csr_index_type CSR_CIPHER_8_15  = 3'd1;
   localparam csr_index_type CSR_CIPHER_16_23 = 3'd2;
   localparam csr_index_type CSR_CIPHER_24_31 = 3'd3;
   localparam csr_index_type CSR_CIPHER_32    = 3'd4;
   localparam csr_index_type CSR_KEY_PREFIX   = 3'd5;
   localparam csr_index_type CSR_MATCH        = 3'd6;

   typedef logic [4:0] upc_type;

   typedef enum logic [1:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_NOT_START,
      COND_NOT_LAST
   } cond_type;

   typedef enum logic [2:0] {
      ADDR_N,
      ADDR_X,
      ADDR_Y,
      ADDR_Y_NEXT,
      ADDR_AB
   } addr_sel_type;

   typedef enum logic [1:0] {
      WD_N,
      WD_RDATA,
      WD_A
   } wdata_sel_type;

   typedef enum logic [1:0] {
      Y_HOLD,
      Y_CLEAR,
      Y_KSA,
      Y_PRGA
   } y_op_type;

   typedef enum logic [1:0] {
      N_HOLD,
      N_CLEAR,
      N_INC
   } n_op_type;

   typedef enum logic [1:0] {
      K_HOLD,
      K_CLEAR,
      K_INC
   } k_op_type;

   typedef enum logic {
      LIM_TABLE,
      LIM_MSG
   } limit_type;

   typedef struct packed {
      cond_type      cond;
      upc_type       target;
      addr_sel_type  addr_sel;
      wdata_sel_type wdata_sel;
      logic          table_we;
      logic          load_a;
      logic          load_b;
      y_op_type      y_op;
      n_op_type      n_op;
      k_op_type      k_op;
      limit_type     limit;
      logic          store_we;
      logic          match_init;
      logic          emit;
   } ctrl_type;

   typedef struct packed {
      logic start;
      logic count_last;
   } status_type;

   localparam upc_type UPC_IDLE    = 5'd0;
   localparam upc_type UPC_SETUP   = 5'd1;
   localparam upc_type UPC_INIT    = 5'd2;
   localparam upc_type UPC_KSA_RD  = 5'd3;
   localparam upc_type UPC_KSA_Y   = 5'd4;
   localparam upc_type UPC_KSA_WN  = 5'd5;
   localparam upc_type UPC_KSA_WY  = 5'd6;
   localparam upc_type UPC_GEN_SET = 5'd7;
   localparam upc_type UPC_GEN_RD  = 5'd8;
   localparam upc_type UPC_GEN_Y   = 5'd9;
   localparam upc_type UPC_GEN_WX  = 5'd10;
   localparam upc_type UPC_GEN_WY  = 5'd11;
   localparam upc_type UPC_GEN_KS  = 5'd12;
   localparam upc_type UPC_GEN_OUT = 5'd13;
   localparam upc_type UPC_OUT_SET = 5'd14;
   localparam upc_type UPC_OUT     = 5'd15;
   localparam upc_type UPC_FINISH  = 5'd16;

   // Microcode ROM: one control word per step.
   function automatic ctrl_type ucode_word(input upc_type upc);
      ctrl_type w;
      w = '0;
      case (upc)
         UPC_IDLE: begin
            w.cond   = COND_NOT_START;
            w.target = UPC_IDLE;
         end
         UPC_SETUP: begin
            w.n_op       = N_CLEAR;
            w.y_op       = Y_CLEAR;
            w.k_op       = K_CLEAR;
         end
         UPC_INIT: begin
            w.addr_sel  = ADDR_N;
            w.wdata_sel = WD_N;
            w.table_we  = 1'b1;
            w.n_op      = N_INC;
            w.limit     = LIM_TABLE;
            w.cond      = COND_NOT_LAST;
            w.target    = UPC_INIT;
         end
         UPC_KSA_RD: begin
            w.addr_sel = ADDR_N;
         end
         UPC_KSA_Y: begin
            w.load_a   = 1'b1;
            w.y_op     = Y_KSA;
            w.addr_sel = ADDR_Y_NEXT;
         end
         UPC_KSA_WN: begin
            w.addr_sel  = ADDR_N;
            w.wdata_sel = WD_RDATA;
            w.table_we  = 1'b1;
         end
         UPC_KSA_WY: begin
            w.addr_sel  = ADDR_Y;
            w.wdata_sel = WD_A;
            w.table_we  = 1'b1;
            w.n_op      = N_INC;
            w.k_op      = K_INC;
            w.limit     = LIM_TABLE;
            w.cond      = COND_NOT_LAST;
            w.target    = UPC_KSA_RD;
         end
         UPC_GEN_SET: begin
            w.y_op       = Y_CLEAR;
            w.n_op       = N_CLEAR;
            w.match_init = 1'b1;
         end
         UPC_GEN_RD: begin
            w.addr_sel = ADDR_X;
         end
         UPC_GEN_Y: begin
            w.load_a   = 1'b1;
            w.y_op     = Y_PRGA;
            w.addr_sel = ADDR_Y_NEXT;
         end
         UPC_GEN_WX: begin
            w.addr_sel  = ADDR_X;
            w.wdata_sel = WD_RDATA;
            w.table_we  = 1'b1;
            w.load_b    = 1'b1;
         end
         UPC_GEN_WY: begin
            w.addr_sel  = ADDR_Y;
            w.wdata_sel = WD_A;
            w.table_we  = 1'b1;
         end
         UPC_GEN_KS: begin
            w.addr_sel = ADDR_AB;
         end
         UPC_GEN_OUT: begin
            w.store_we = 1'b1;
            w.n_op     = N_INC;
            w.limit    = LIM_MSG;
            w.cond     = COND_NOT_LAST;
            w.target   = UPC_GEN_RD;
         end
         UPC_OUT_SET: begin
            w.n_op = N_CLEAR;
         end
         UPC_OUT: begin
            w.emit   = 1'b1;
            w.n_op   = N_INC;
            w.limit  = LIM_MSG;
            w.cond   = COND_NOT_LAST;
            w.target = UPC_OUT;
         end
         UPC_FINISH: begin
            w.cond   = COND_ALWAYS;
            w.target = UPC_IDLE;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = UPC_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/rc4_key_candidate_tester.sv
// RC4 key candidate tester. The plaintext transfers of a candidate follow its key schedule
// and keystream generation, one transfer per cycle until all MESSAGE_BYTES bytes are out.
// A new candidate is accepted only once the last one is through; the pace is set by the
// single-port permutation table, which needs four accesses per swap of the key schedule.
// Reset is synchronous and active high; it restores the register defaults and idles the block.
// The receiver cannot stall: each result is presented for exactly one cycle.
`default_nettype none

module rc4_key_candidate_tester #(
   parameter int KEY_BYTES     = 11,
   parameter int MESSAGE_BYTES = 33
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // Candidate input channel.
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [7:0]                req_month,
   input  wire logic [7:0]                req_day,
   input  wire logic [7:0]                req_hour,
   input  wire logic [7:0]                req_major_version,
   input  wire logic [7:0]                req_minor_version,
   input  wire logic [7:0]                req_debugged,
   input  wire logic [7:0]                req_language,
   // Plaintext result channel.
   output logic                           rsp_valid,
   output logic      [7:0]                rsp_plain_byte,
   output logic      [5:0]                rsp_byte_index,
   output logic                           rsp_prefix_match,
   output logic                           rsp_last,
   // Configuration write port.
   input  wire logic                      csr_wr_en,
   input  wire rc4kct_pkg::csr_index_type csr_index,
   input  wire logic [63:0]               csr_wdata
);
   import rc4kct_pkg::*;

   localparam int KW = $clog2(KEY_BYTES);
   localparam int PW = $clog2(MESSAGE_BYTES);

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   logic [63:0] cipher_ff [4];
   logic [7:0]  cipher32_ff;
   logic [31:0] key_prefix_ff;
   logic [31:0] match_pattern_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            cipher_ff[i] <= '0;
         end
         cipher32_ff      <= '0;
         key_prefix_ff    <= KEY_PREFIX_RESET;
         match_pattern_ff <= MATCH_PATTERN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CIPHER_0_7:   cipher_ff[0]     <= csr_wdata;
            CSR_CIPHER_8_15:  cipher_ff[1]     <= csr_wdata;
            CSR_CIPHER_16_23: cipher_ff[2]     <= csr_wdata;
            CSR_CIPHER_24_31: cipher_ff[3]     <= csr_wdata;
            CSR_CIPHER_32:    cipher32_ff      <= csr_wdata[7:0];
            CSR_KEY_PREFIX:   key_prefix_ff    <= csr_wdata[31:0];
            CSR_MATCH:        match_pattern_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // The ciphertext as one flat vector, byte 0 in the low bits.
   logic [263:0] cipher_vec;
   assign cipher_vec = {cipher32_ff, cipher_ff[3], cipher_ff[2], cipher_ff[1], cipher_ff[0]};

   // ------------------------------------------------------------------
   // Sequencer.
   // ------------------------------------------------------------------
   ctrl_type   ctrl;
   status_type status;
   logic       accept;

   assign accept = start && !busy;

   rc4kct_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   // ------------------------------------------------------------------
   // Key capture. The key is built once, at the accepting edge: four prefix
   // bytes, then each candidate field plus its offset. Fields past the end
   // of a short key are dropped, and a long key is padded with zero bytes.
   // ------------------------------------------------------------------
   logic [7:0] field_in [FIELD_COUNT];
   logic [7:0] key_in   [KEY_BYTES];
   logic [7:0] key_ff   [KEY_BYTES];

   assign field_in[0] = req_month;
   assign field_in[1] = req_day;
   assign field_in[2] = req_hour;
   assign field_in[3] = req_major_version;
   assign field_in[4] = req_minor_version;
   assign field_in[5] = req_debugged;
   assign field_in[6] = req_language;

   for (genvar g = 0; g < KEY_BYTES; g++) begin : g_key
      if (g < PREFIX_BYTES) begin : g_prefix
         assign key_in[g] = key_prefix_ff[31-8*g -: 8];
      end else if (g < PREFIX_BYTES + FIELD_COUNT) begin : g_field
         assign key_in[g] = field_in[g-PREFIX_BYTES] + FIELD_OFFSET[g-PREFIX_BYTES];
      end else begin : g_pad
         assign key_in[g] = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff <= key_in;
      end
   end

   // ------------------------------------------------------------------
   // Datapath registers: loop counter n, key index k, RC4 index y, and
   // the two swap operands a and b.
   // ------------------------------------------------------------------
   logic [7:0]    n_ff, n_in;
   logic [KW-1:0] k_ff, k_in;
   logic [7:0]    y_ff, y_in;
   logic [7:0]    a_ff, a_in;
   logic [7:0]    b_ff, b_in;
   logic          match_ff, match_in;
   logic [7:0]    table_rdata;
   logic [7:0]    y_next;
   logic [7:0]    x_val;
   logic [7:0]    limit_val;
   logic [7:0]    plain_val;
   logic [1:0]    pat_sel;
   logic [7:0]    pat_byte;

   assign x_val = n_ff + 8'd1;

   // The new y feeds the table address in the same cycle that the read data arrives.
   assign y_next = (ctrl.y_op == Y_KSA) ? y_ff + table_rdata + key_ff[k_ff]
                                        : y_ff + table_rdata;

   assign limit_val = (ctrl.limit == LIM_MSG) ? 8'(MESSAGE_BYTES - 1)
                                              : 8'(TABLE_DEPTH - 1);

   assign status.start      = start;
   assign status.count_last = (n_ff == limit_val);

   assign plain_val = table_rdata ^ cipher_vec[{n_ff[5:0], 3'b000} +: 8];
   assign pat_sel   = 2'd3 - n_ff[1:0];
   assign pat_byte  = match_pattern_ff[{pat_sel, 3'b000} +: 8];

   always_comb begin
      case (ctrl.n_op)
         N_CLEAR: n_in = '0;
         N_INC:   n_in = n_ff + 8'd1;
         default: n_in = n_ff;
      endcase

      case (ctrl.k_op)
         K_CLEAR: k_in = '0;
         K_INC:   k_in = (k_ff == KW'(KEY_BYTES - 1)) ? '0 : k_ff + KW'(1);
         default: k_in = k_ff;
      endcase

      case (ctrl.y_op)
         Y_CLEAR: y_in = '0;
         Y_KSA:   y_in = y_next;
         Y_PRGA:  y_in = y_next;
         default: y_in = y_ff;
      endcase

      a_in = ctrl.load_a ? table_rdata : a_ff;
      b_in = ctrl.load_b ? table_rdata : b_ff;

      // The match flag starts true and is cleared by any mismatch in the
      // first four plaintext bytes.
      match_in = match_ff;
      if (ctrl.match_init) begin
         match_in = 1'b1;
      end else if (ctrl.store_we && (n_ff[7:2] == 6'd0) && (plain_val != pat_byte)) begin
         match_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff     <= '0;
         k_ff     <= '0;
         y_ff     <= '0;
         match_ff <= 1'b0;
      end else begin
         n_ff     <= n_in;
         k_ff     <= k_in;
         y_ff     <= y_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

   // ------------------------------------------------------------------
   // Permutation table.
   // ------------------------------------------------------------------
   logic [7:0] table_addr;
   logic [7:0] table_wdata;

   always_comb begin
      case (ctrl.addr_sel)
         ADDR_N:      table_addr = n_ff;
         ADDR_X:      table_addr = x_val;
         ADDR_Y:      table_addr = y_ff;
         ADDR_Y_NEXT: table_addr = y_next;
         ADDR_AB:     table_addr = a_ff + b_ff;
         default:     table_addr = n_ff;
      endcase

      case (ctrl.wdata_sel)
         WD_N:     table_wdata = n_ff;
         WD_RDATA: table_wdata = table_rdata;
         WD_A:     table_wdata = a_ff;
         default:  table_wdata = n_ff;
      endcase
   end

   rc4kct_ram #(
      .WIDTH (8),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ctrl.table_we),
      .addr  (table_addr),
      .wdata (table_wdata),
      .rdata (table_rdata)
   );

   // ------------------------------------------------------------------
   // Plaintext store. Bytes are written during generation and read back in
   // order once the match flag is final.
   // ------------------------------------------------------------------
   logic [7:0] store_rdata;

   rc4kct_ram #(
      .WIDTH (8),
      .DEPTH (MESSAGE_BYTES)
   ) u_store (
      .clock (clock),
      .we    (ctrl.store_we),
      .addr  (n_ff[PW-1:0]),
      .wdata (plain_val),
      .rdata (store_rdata)
   );

   // ------------------------------------------------------------------
   // Result strobe. The store's registered read lines up with these flags.
   // ------------------------------------------------------------------
   logic       emit_ff;
   logic       last_ff;
   logic [5:0] index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff <= 1'b0;
         last_ff <= 1'b0;
      end else begin
         emit_ff <= ctrl.emit;
         last_ff <= ctrl.emit && status.count_last;
      end
   end

   always_ff @(posedge clock) begin
      index_ff <= n_ff[5:0];
   end

   assign rsp_valid        = emit_ff;
   assign rsp_plain_byte   = store_rdata;
   assign rsp_byte_index   = index_ff;
   assign rsp_prefix_match = match_ff;
   assign rsp_last         = last_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   a_valid_while_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result transfer outside a busy window");

   a_start_takes : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted candidate did not start the sequencer");

   a_last_index : assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_valid && (rsp_byte_index == 6'(MESSAGE_BYTES - 1)))
      else $error("last flag on a wrong byte");

   a_burst_order : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid && (rsp_byte_index == $past(rsp_byte_index) + 6'd1))
      else $error("result burst broken or out of order");

endmodule

`default_nettype wire

FILE: rtl/rc4kct_ram.sv
// Generic single-port RAM with a registered read port.
// It has no dependencies. The top level uses it for the permutation table and plaintext store.
`default_nettype none

module rc4kct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: rtl/rc4kct_sequencer.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// It depends on rc4kct_pkg for the control word, status and ROM.
`default_nettype none

module rc4kct_sequencer (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rc4kct_pkg::status_type status,
   output rc4kct_pkg::ctrl_type        ctrl,
   output logic                        busy
);
   import rc4kct_pkg::*;

   upc_type upc_ff;
   upc_type upc_in;

   assign ctrl = ucode_word(upc_ff);
   assign busy = (upc_ff != UPC_IDLE);

   always_comb begin
      case (ctrl.cond)
         COND_NONE:      upc_in = upc_ff + 5'd1;
         COND_ALWAYS:    upc_in = ctrl.target;
         COND_NOT_START: upc_in = status.start ? upc_ff + 5'd1 : ctrl.target;
         COND_NOT_LAST:  upc_in = status.count_last ? upc_ff + 5'd1 : ctrl.target;
         default:        upc_in = UPC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UPC_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

`default_nettype wire

FILE: tb/sv/tb_rc4_key_candidate_tester.sv
// Self-checking testbench for rc4_key_candidate_tester: directed table, then random candidates.
// It depends on rc4kct_pkg for the register indexes, offsets and reset values, and on the RTL.
module tb_rc4_key_candidate_tester;
   timeunit 1ns;
   timeprecision 1ps;

   import rc4kct_pkg::*;

   localparam int CLOCK_PERIOD    = 20;
   localparam int RESET_CYCLES    = 10;
   localparam int KEY_BYTES       = 11;
   localparam int MSG_BYTES       = 33;
   localparam int RANDOM_ITEMS    = 360;
   localparam int PHASE_ITEMS     = 48;
   localparam int QUIET_ITEMS     = 40;
   localparam int END_CYCLES      = 100;
   // The first byte of a candidate follows its key schedule and keystream generation; this
   // limit is several times the longest silent stretch.
   localparam int WATCHDOG_CYCLES = 10000;

   // Index 7 decodes to no register, so a write there must leave every register alone.
   localparam csr_index_type CSR_UNUSED = 3'd7;

   // Candidate fields in key order: month, day, hour, major, minor, debugged, language.
   typedef logic [0:FIELD_COUNT-1][7:0] candidate_type;
   typedef logic [0:MSG_BYTES-1][7:0] stream_type;

   typedef struct packed {
      logic [7:0] plain_byte;
      logic [5:0] byte_index;
      logic       prefix_match;
      logic       last;
   } plaintext_beat_type;

   typedef enum logic [1:0] {
      GAP_NONE,
      GAP_NOW,
      GAP_AFTER_BUSY
   } gap_mode_type;

   typedef enum logic [1:0] {
      ROW_WRITE,
      ROW_CAND,
      ROW_MATCH
   } row_kind_type;

   // A ROW_MATCH row forces the first four plaintext bytes to data[63:32] by rewriting the
   // low ciphertext word, then programs the pattern as data[63:32] ^ data[31:0].
   typedef struct packed {
      row_kind_type  kind;
      csr_index_type index;
      logic [63:0]   data;
      candidate_type cand;
      logic          exp_match;
   } row_type;

   localparam int DIRECTED_ROWS = 27;

   row_type directed_rows [DIRECTED_ROWS] = '{
      // Register defaults straight after reset, field extremes and key-byte wraparound.
      '{ROW_CAND,  CSR_CIPHER_0_7,   64'h0,                  56'h00_00_00_00_00_00_00, 1'b0},
      '{ROW_CAND,  CSR_CIPHER_0_7,   64'h0,                  56'hff_ff_ff_ff_ff_ff_ff, 1'b0},
      '{ROW_CAND,  CSR_CIPHER_0_7,   64'h0,                  56'haa_55_aa_55_aa_55_aa, 1'b0},
      '{ROW_CAND,  CSR_CIPHER_0_7,   64'h0,                  56'hcb_d7_c0_8d_a3_c1_95, 1'b0},
      '{ROW_CAND,  CSR_CIPHER_0_7,   64'h0,                  56'hca_d6_bf_8c_a2_c0_94, 1'b0},
      // A write to an unused index is dropped, so the repeat of the first row must agree.
      '{ROW_WRITE, CSR_UNUSED,       64'hffffffff_ffffffff,  56'h0,                    1'b0},
      '{ROW_CAND,  CSR_CIPHER_0_7,   64'h0,                  56'h00_00_00_00_00_00_00, 1'b0},
      // Every register, with bits above the narrow registers' widths set.
      '{ROW_WRITE, CSR_CIPHER_0_7,   64'hffffffff_ffffffff,  56'h0,                    1'b0},
      '{ROW_WRITE, CSR_CIPHER_8_15,  64'h01234567_89abcdef,  56'h0,                    1'b0},
      '{ROW_WRITE, CSR_CIPHER_16_23, 64'hfedcba98_76543210,  56'h0,                    1'b0},
      '{ROW_WRITE, CSR_CIPHER_24_31, 64'h80000000_00000001,  56'h0,                    1'b0},
      '{ROW_WRITE, CSR_CIPHER_32,    64'hffffffff_ffffff5a,  56'h0,                    1'b0},
      '{ROW_WRITE, CSR_KEY_PREFIX,   64'hffffffff_00000000,  56'h0,                    1'b0},
      '{ROW_WRITE, CSR_MATCH,        64'h01234567_00000000,  56'h0,                    1'b0},
      '{ROW_CAND,  CSR_CIPHER_0_7,   64'h0,                  56'h00_00_00_00_00_00_00, 1'b0},
      '{ROW_CAND,  CSR_CIPHER_0_7,   64'h0,                  56'hff_ff_ff_ff_ff_ff_ff, 1'b0},
      '{ROW_CAND,  CSR_CIPHER_0_7,   64'h0,                  56'h12_34_56_78_9a_bc_de, 1'b0},
      '{ROW_WRITE, CSR_KEY_PREFIX,   64'h00000000_ffffffff,  56'h0,                    1'b0},
      '{ROW_CAND,  CSR_CIPHER_0_7,   64'h0,                  56'h01_02_04_08_10_20_40, 1'b0},
      '{ROW_CAND,  CSR_CIPHER_0_7,   64'h0,                  56'hfe_fd_fb_f7_ef_df_bf, 1'b0},
      // Pattern compare: an all-zero pattern matches, and a single flipped bit misses.
      '{ROW_MATCH, CSR_MATCH,        64'h00000000_00000000,  56'h00_00_00_00_00_00_00, 1'b1},
      '{ROW_MATCH, CSR_MATCH,        64'h4b65793a_00000000,  56'h07_03_11_01_02_00_09, 1'b1},
      '{ROW_MATCH, CSR_MATCH,        64'h4b65793a_00000001,  56'h07_03_11_01_02_00_09, 1'b0},
      '{ROW_MATCH, CSR_MATCH,        64'h00ff00ff_80000000,  56'h0c_1f_17_01_00_00_ff, 1'b0},
      '{ROW_MATCH, CSR_MATCH,        64'hffffffff_00000000,  56'hff_ff_ff_ff_ff_ff_ff, 1'b1},
      '{ROW_WRITE, CSR_CIPHER_32,    64'h00000000_00000000,  56'h0,                    1'b0},
      '{ROW_CAND,  CSR_CIPHER_0_7,   64'h0,                  56'h80_80_80_80_80_80_80, 1'b0}
   };

   // Clock, reset and every block input start at known values.
   logic                clock              = 1'b0;
   logic                reset              = 1'b1;
   logic                start              = 1'b0;
   logic [7:0]          req_month          = 8'h00;
   logic [7:0]          req_day            = 8'h00;
   logic [7:0]          req_hour           = 8'h00;
   logic [7:0]          req_major_version  = 8'h00;
   logic [7:0]          req_minor_version  = 8'h00;
   logic [7:0]          req_debugged       = 8'h00;
   logic [7:0]          req_language       = 8'h00;
   logic                csr_wr_en          = 1'b0;
   csr_index_type       csr_index          = CSR_CIPHER_0_7;
   logic [63:0]         csr_wdata          = 64'h0;
   logic                busy;
   logic                rsp_valid;
   logic [7:0]          rsp_plain_byte;
   logic [5:0]          rsp_byte_index;
   logic                rsp_prefix_match;
   logic                rsp_last;

   // Shadow copy of the register file, kept in step with every write.
   logic [63:0]         cipher_shadow [4] = '{64'h0, 64'h0, 64'h0, 64'h0};
   logic [7:0]          cipher_last_shadow = 8'h00;
   logic [31:0]         key_prefix_shadow  = KEY_PREFIX_RESET;
   logic [31:0]         match_shadow       = MATCH_PATTERN_RESET;

   plaintext_beat_type  pending_plaintext [$];
   int                  mismatch_count = 0;
   int                  idle_cycles    = 0;
   bit                  start_drive    = 1'b0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   rc4_key_candidate_tester #(
      .KEY_BYTES     (KEY_BYTES),
      .MESSAGE_BYTES (MSG_BYTES)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_month         (req_month),
      .req_day           (req_day),
      .req_hour          (req_hour),
      .req_major_version (req_major_version),
      .req_minor_version (req_minor_version),
      .req_debugged      (req_debugged),
      .req_language      (req_language),
      .rsp_valid         (rsp_valid),
      .rsp_plain_byte    (rsp_plain_byte),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_prefix_match  (rsp_prefix_match),
      .rsp_last          (rsp_last),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // Keystream for one candidate under the current key prefix. The key is the prefix, then
   // each field plus its offset, then zero bytes if the key is longer than prefix plus fields.
   // The schedule and the generator follow the textbook RC4 loops exactly.
   function automatic stream_type rc4_keystream(input candidate_type cand);
      logic [7:0] perm [TABLE_DEPTH];
      logic [7:0] key [KEY_BYTES];
      logic [7:0] a, b, x, y;
      int         k, n;
      stream_type ks;
      for (k = 0; k < KEY_BYTES; k++) begin
         if (k < PREFIX_BYTES) begin
            key[k] = key_prefix_shadow[31 - 8 * k -: 8];
         end else if (k < PREFIX_BYTES + FIELD_COUNT) begin
            key[k] = cand[k - PREFIX_BYTES] + FIELD_OFFSET[k - PREFIX_BYTES];
         end else begin
            key[k] = 8'h00;
         end
      end
      for (n = 0; n < TABLE_DEPTH; n++) begin
         perm[n] = 8'(n);
      end
      y = 8'h00;
      k = 0;
      for (n = 0; n < TABLE_DEPTH; n++) begin
         a       = perm[n];
         y       = y + a + key[k];
         perm[n] = perm[y];
         perm[y] = a;
         k       = (k == KEY_BYTES - 1) ? 0 : k + 1;
      end
      y = 8'h00;
      for (n = 0; n < MSG_BYTES; n++) begin
         x       = 8'(n + 1);
         a       = perm[x];
         y       = y + a;
         b       = perm[y];
         perm[x] = b;
         perm[y] = a;
         ks[n]   = perm[8'(a + b)];
      end
      return ks;
   endfunction

   // Queues the plaintext transfers that one accepted candidate must produce.
   function automatic void predict_plaintext(input candidate_type cand);
      stream_type         ks;
      logic [7:0]         plain [MSG_BYTES];
      logic [7:0]         cipher_byte;
      logic               hit;
      plaintext_beat_type beat;
      ks = rc4_keystream(cand);
      for (int n = 0; n < MSG_BYTES; n++) begin
         if (n < 32) begin
            cipher_byte = cipher_shadow[n / 8][8 * (n % 8) +: 8];
         end else begin
            cipher_byte = cipher_last_shadow;
         end
         plain[n] = ks[n] ^ cipher_byte;
      end
      hit = ({plain[0], plain[1], plain[2], plain[3]} == match_shadow);
      for (int n = 0; n < MSG_BYTES; n++) begin
         beat.plain_byte   = plain[n];
         beat.byte_index   = 6'(n);
         beat.prefix_match = hit;
         beat.last         = (n == MSG_BYTES - 1);
         pending_plaintext.push_back(beat);
      end
   endfunction

   // Fields lean toward their extremes so that wrap of the key byte sums is common.
   function automatic logic [7:0] random_field();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return 8'h00;
      if (pick == 1) return 8'hff;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [63:0] random_csr_value();
      int pick;
      pick = $urandom_range(0, 3);
      if (pick == 0) return 64'h0;
      if (pick == 1) return '1;
      return {$urandom, $urandom};
   endfunction

   // Sender idling: mostly none, otherwise a short burst right after the previous start
   // transfer or a burst that begins once the block has gone idle.
   function automatic gap_mode_type pick_gap(input bit quiet);
      int pick;
      pick = $urandom_range(0, 5);
      if (quiet) return GAP_NONE;
      if (pick == 0) return GAP_NOW;
      if (pick == 1) return GAP_AFTER_BUSY;
      return GAP_NONE;
   endfunction

   // The start strobe is only changed through these two paths, so it never takes two
   // nonblocking assignments in one time step.
   task automatic lower_start();
      if (start_drive) begin
         start       <= 1'b0;
         start_drive  = 1'b0;
      end
   endtask

   // Writes one register at the next rising edge and mirrors the write in the shadow copy.
   // The write enable stays high until csr_release, so back-to-back writes need no toggle.
   task automatic csr_write(input csr_index_type index, input logic [63:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_CIPHER_0_7, CSR_CIPHER_8_15, CSR_CIPHER_16_23, CSR_CIPHER_24_31: begin
            cipher_shadow[index[1:0]] = value;
         end
         CSR_CIPHER_32:  cipher_last_shadow = value[7:0];
         CSR_KEY_PREFIX: key_prefix_shadow  = value[31:0];
         CSR_MATCH:      match_shadow       = value[31:0];
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   task automatic csr_release();
      csr_wr_en <= 1'b0;
   endtask

   // Holds start low until every expected transfer has arrived and the block is idle.
   // The loop waits on the clock first, so a next start never shares a step with the drop.
   task automatic wait_for_drain();
      lower_start();
      do @(posedge clock); while (pending_plaintext.size() != 0 || busy);
   endtask

   // Presents one candidate and returns at the edge that accepts it, with start still high.
   // The prediction is made at that edge, under the registers in force at that moment.
   task automatic send_candidate(input candidate_type cand, input gap_mode_type gap);
      int burst;
      if (gap != GAP_NONE) begin
         lower_start();
         if (gap == GAP_AFTER_BUSY) begin
            do @(posedge clock); while (busy);
         end
         burst = $urandom_range(1, 10);
         repeat (burst) @(posedge clock);
      end
      req_month         <= cand[0];
      req_day           <= cand[1];
      req_hour          <= cand[2];
      req_major_version <= cand[3];
      req_minor_version <= cand[4];
      req_debugged      <= cand[5];
      req_language      <= cand[6];
      if (!start_drive) begin
         start       <= 1'b1;
         start_drive  = 1'b1;
      end
      do @(posedge clock); while (busy);
      predict_plaintext(cand);
   endtask

   // Rewrites the low ciphertext word so that the first four plaintext bytes come out as
   // the given pattern, programs it with the bits in flip inverted, and sends the candidate.
   // The first four bytes and the match flag are then known without the predictor, so those
   // fields of the queued transfers are replaced with the stated values.
   task automatic send_with_pattern(input candidate_type cand, input logic [31:0] pattern,
                                    input logic [31:0] flip, input logic want_match,
                                    input gap_mode_type gap);
      stream_type         ks;
      logic [63:0]        word0;
      plaintext_beat_type beat;
      int                 base;
      wait_for_drain();
      ks    = rc4_keystream(cand);
      word0 = cipher_shadow[0];
      for (int n = 0; n < 4; n++) begin
         word0[8 * n +: 8] = ks[n] ^ pattern[31 - 8 * n -: 8];
      end
      csr_write(CSR_CIPHER_0_7, word0);
      csr_write(CSR_MATCH, {32'h0, pattern ^ flip});
      csr_release();
      send_candidate(cand, gap);
      base = pending_plaintext.size() - MSG_BYTES;
      for (int n = 0; n < MSG_BYTES; n++) begin
         beat = pending_plaintext[base + n];
         if (n < 4) beat.plain_byte = pattern[31 - 8 * n -: 8];
         beat.prefix_match = want_match;
         pending_plaintext[base + n] = beat;
      end
   endtask

   // Result checker. The receiver cannot stall, so every strobe is one transfer, compared
   // field by field with the oldest expectation. Outputs are sampled at the edge that ends
   // the transfer cycle, before the block's own updates at that edge take effect.
   always @(posedge clock) begin
      plaintext_beat_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_plaintext.size() == 0) begin
            $error("plaintext transfer with nothing expected: byte_index %0d, plain_byte %02h",
                   rsp_byte_index, rsp_plain_byte);
            mismatch_count++;
         end else begin
            want = pending_plaintext.pop_front();
            if (rsp_plain_byte !== want.plain_byte) begin
               $error("plain_byte mismatch: expected %02h, actual %02h",
                      want.plain_byte, rsp_plain_byte);
               mismatch_count++;
            end
            if (rsp_byte_index !== want.byte_index) begin
               $error("byte_index mismatch: expected %0d, actual %0d",
                      want.byte_index, rsp_byte_index);
               mismatch_count++;
            end
            if (rsp_prefix_match !== want.prefix_match) begin
               $error("prefix_match mismatch at byte %0d: expected %0b, actual %0b",
                      want.byte_index, want.prefix_match, rsp_prefix_match);
               mismatch_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last mismatch at byte %0d: expected %0b, actual %0b",
                      want.byte_index, want.last, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: any start transfer or result transfer counts as progress. A hung block shows
   // up as a long run of cycles without either.
   always @(posedge clock) begin
      if (rsp_valid === 1'b1 || (start === 1'b1 && busy === 1'b0)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      row_type       row;
      candidate_type cand;
      logic [63:0]   value;
      logic [31:0]   flip;
      bit            quiet;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part: write rows wait for the block to drain before they touch a register.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = directed_rows[i];
         case (row.kind)
            ROW_WRITE: begin
               wait_for_drain();
               csr_write(row.index, row.data);
               csr_release();
            end
            ROW_CAND: begin
               send_candidate(row.cand, pick_gap(1'b0));
            end
            default: begin
               send_with_pattern(row.cand, row.data[63:32], row.data[31:0], row.exp_match,
                                 pick_gap(1'b0));
            end
         endcase
      end

      // Random part, in phases. Each phase starts from an idle block with a fresh mix of
      // register values, extremes included. About one candidate in ten is sent with a forced
      // pattern, which also makes the sender wait until every expected transfer has come.
      // The last stretch runs with no idling at all, so no phase begins inside it.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         quiet = (i >= RANDOM_ITEMS - QUIET_ITEMS);
         if (!quiet && i % PHASE_ITEMS == 0) begin
            wait_for_drain();
            for (int r = 0; r <= int'(CSR_MATCH); r++) begin
               if ($urandom_range(0, 2) != 0) csr_write(csr_index_type'(r), random_csr_value());
            end
            if ($urandom_range(0, 3) == 0) csr_write(CSR_UNUSED, random_csr_value());
            csr_release();
         end
         for (int f = 0; f < FIELD_COUNT; f++) begin
            cand[f] = random_field();
         end
         if (!quiet && $urandom_range(0, 9) == 0) begin
            value = random_csr_value();
            flip  = ($urandom_range(0, 1) == 0) ? 32'h0 : (32'h1 << $urandom_range(0, 31));
            send_with_pattern(cand, value[31:0], flip, (flip == 32'h0), GAP_NONE);
         end else begin
            send_candidate(cand, pick_gap(quiet));
         end
      end

      // Let the last candidate finish, then keep watching for stray transfers before the verdict.
      wait_for_drain();
      repeat (END_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_plaintext.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/rc4kct_pkg.sv
rtl/rc4kct_ram.sv
rtl/rc4kct_sequencer.sv
rtl/rc4_key_candidate_tester.sv
tb/sv/tb_rc4_key_candidate_tester.sv
